>>> hw/rtl/amcp_pkg.sv
// ----------------------------------------------------------------------------
// amcp_pkg
// Shared types and constants for the ASCII move command parser: request codes,
// character codes, parse phases and the result queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amcp_pkg;

    // Output field widths
    localparam int COORD_W = 24;
    localparam int TOTAL_W = 6;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int Q_AW   = 2;
    localparam int Q_CW   = 3;

    // Request codes
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_HOME  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;
    localparam logic [1:0] REQ_MOVE  = 2'd3;

    // Result kinds
    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    // Coordinate slot holding the third number of a triple
    localparam logic [1:0] COORD_LAST = 2'd2;

    // Parse phase, one-hot
    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_MOVE  = 3'b010,
        PH_STOP  = 3'b100
    } phase_t;

    // One queued result transaction
    typedef struct packed {
        logic               kind;
        logic [1:0]         req;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [TOTAL_W-1:0] total;
    } qent_t;

endpackage

>>> hw/rtl/ascii_move_command_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_move_command_parser_core
// Byte-wide command parser: selects a request from the first byte and, for a
// move, turns triples of decimal numbers into segment results, closing each
// command with a summary result.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_ready is high; results are queued.
// A byte that yields a segment and the summary places two results in the
// four-entry result queue, which drains one result per cycle while out_ready
// is high; in_ready drops while fewer than two queue slots are free.
// Reset: rst_n clears parse state and queue pointers at once; queue payload
// is not cleared.
`timescale 1ns / 1ps

module ascii_move_command_parser_core
    import amcp_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32,
    parameter int VALUE_BITS   = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         byte_value,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               item_kind,
    output logic [1:0]         request_kind,
    output logic [COORD_W-1:0] coord_x,
    output logic [COORD_W-1:0] coord_y,
    output logic [COORD_W-1:0] coord_z,
    output logic [TOTAL_W-1:0] segment_total,
    output logic               end_of_run
);

    localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int PROD_W = VALUE_BITS + 4;

    typedef logic [VALUE_BITS-1:0] acc_arr_t [3];

    // Narrow a coordinate to its port width
    function automatic logic [COORD_W-1:0] to_coord(input logic [VALUE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[COORD_W-1:0];
    endfunction

    // Narrow the segment count to its port width
    function automatic logic [TOTAL_W-1:0] to_total(input logic [SEG_W-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[TOTAL_W-1:0];
    endfunction

    // Parse state
    phase_t         phase_reg, phase_next;
    logic [1:0]     req_reg, req_next;
    logic [1:0]     ci_reg, ci_next;
    logic           innum_reg, innum_next;
    acc_arr_t       acc_reg, acc_next;
    logic [SEG_W-1:0] seg_reg, seg_next;

    // Results of the current byte
    logic           emit_seg, emit_sum;
    acc_arr_t       seg_vals;
    logic [1:0]     sum_req;
    logic [SEG_W-1:0] sum_total;

    // Result queue
    qent_t          q_mem [QDEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] q_count_reg;
    qent_t          seg_entry, sum_entry, first_entry, head;
    logic           in_fire, out_fire;
    logic [Q_CW-1:0] push_cnt;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (q_count_reg <= Q_CW'(QDEPTH - 2));

    // Work out next parse state and results for the presented byte
    always_comb
    begin : next_state_comb
        logic [1:0]        ci;
        logic              digit;
        logic              cont;
        logic [3:0]        dval;
        logic [7:0]        doff;
        logic [PROD_W-1:0] ext;
        logic [PROD_W-1:0] prod;
        logic [VALUE_BITS-1:0] sat_val;

        phase_next = phase_reg;
        req_next   = req_reg;
        ci_next    = ci_reg;
        innum_next = innum_reg;
        acc_next   = acc_reg;
        seg_next   = seg_reg;
        emit_seg   = 1'b0;
        emit_sum   = 1'b0;
        seg_vals   = '{default: '0};
        sum_req    = REQ_NONE;
        sum_total  = '0;
        cont       = 1'b1;

        // Clamp the coordinate slot and form the times-ten accumulation
        ci    = (ci_reg == 2'd3) ? COORD_LAST : ci_reg;
        digit = byte_value inside {[CHAR_0:CHAR_9]};
        doff  = byte_value - CHAR_0;
        dval  = doff[3:0];
        ext   = PROD_W'(acc_reg[ci]);
        prod  = (ext << 3) + (ext << 1) + PROD_W'(dval);
        if (prod[PROD_W-1:VALUE_BITS] != '0)
            sat_val = '1;
        else
            sat_val = prod[VALUE_BITS-1:0];

        case (phase_reg)
            PH_FIRST:
            begin
                case (byte_value)
                    CHAR_H:  req_next = REQ_HOME;
                    CHAR_R:  req_next = REQ_RESET;
                    CHAR_M:  req_next = REQ_MOVE;
                    default: req_next = REQ_NONE;
                endcase
                phase_next = (req_next == REQ_MOVE) ? PH_MOVE : PH_STOP;
                ci_next    = 2'd0;
                innum_next = 1'b0;
                acc_next   = '{default: '0};
                seg_next   = '0;
            end
            PH_MOVE:
            begin
                // Extend or close the number in progress
                if (innum_reg)
                begin
                    if (digit)
                    begin
                        acc_next[ci] = sat_val;
                        cont         = 1'b0;
                    end
                    else
                    begin
                        innum_next = 1'b0;
                        if (ci == COORD_LAST)
                        begin
                            emit_seg = 1'b1;
                            seg_vals = acc_reg;
                            seg_next = seg_reg + 1'b1;
                            ci_next  = 2'd0;
                            acc_next = '{default: '0};
                            if (seg_next >= SEG_W'(MAX_SEGMENTS))
                            begin
                                phase_next = PH_STOP;
                                cont       = 1'b0;
                            end
                            ci = 2'd0;
                        end
                        else
                        begin
                            ci      = ci + 2'd1;
                            ci_next = ci;
                        end
                    end
                end
                // Skip separators, open a number or stop on anything else
                if (cont)
                begin
                    if (byte_value == CHAR_SPACE)
                    begin
                        cont = 1'b0;
                    end
                    else if (digit)
                    begin
                        innum_next   = 1'b1;
                        acc_next[ci] = VALUE_BITS'(dval);
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
            end
            default:
            begin
                cont = 1'b0;
            end
        endcase

        // Close the command: flush a finished triple, then the summary
        if (last_byte)
        begin
            if (phase_next == PH_MOVE && innum_next && ci_next == COORD_LAST)
            begin
                emit_seg = 1'b1;
                seg_vals = acc_next;
                seg_next = seg_next + 1'b1;
            end
            emit_sum   = 1'b1;
            sum_req    = req_next;
            sum_total  = seg_next;
            phase_next = PH_FIRST;
            req_next   = REQ_NONE;
            ci_next    = 2'd0;
            innum_next = 1'b0;
            acc_next   = '{default: '0};
            seg_next   = '0;
        end
    end

    // Advance parse state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            req_reg   <= REQ_NONE;
            ci_reg    <= 2'd0;
            innum_reg <= 1'b0;
            acc_reg   <= '{default: '0};
            seg_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            req_reg   <= req_next;
            ci_reg    <= ci_next;
            innum_reg <= innum_next;
            acc_reg   <= acc_next;
            seg_reg   <= seg_next;
        end
    end

    // Build queue entries
    always_comb
    begin
        seg_entry.kind  = KIND_SEGMENT;
        seg_entry.req   = REQ_MOVE;
        seg_entry.x     = to_coord(seg_vals[0]);
        seg_entry.y     = to_coord(seg_vals[1]);
        seg_entry.z     = to_coord(seg_vals[2]);
        seg_entry.total = '0;

        sum_entry.kind  = KIND_SUMMARY;
        sum_entry.req   = sum_req;
        sum_entry.x     = '0;
        sum_entry.y     = '0;
        sum_entry.z     = '0;
        sum_entry.total = to_total(sum_total);

        first_entry = emit_seg ? seg_entry : sum_entry;
        push_cnt    = in_fire ? (Q_CW'(emit_seg) + Q_CW'(emit_sum)) : '0;
    end

    // Write results into the queue
    always_ff @(posedge clk)
    begin
        if (in_fire && (emit_seg || emit_sum))
            q_mem[wr_ptr_reg] <= first_entry;
        if (in_fire && emit_seg && emit_sum)
            q_mem[Q_AW'(wr_ptr_reg + 1'b1)] <= sum_entry;
    end

    // Track queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= Q_AW'(Q_CW'(wr_ptr_reg) + push_cnt);
            rd_ptr_reg  <= rd_ptr_reg + Q_AW'(out_fire);
            q_count_reg <= q_count_reg + push_cnt - Q_CW'(out_fire);
        end
    end

    // Present the queue head
    assign head          = q_mem[rd_ptr_reg];
    assign out_valid     = (q_count_reg != '0);
    assign item_kind     = head.kind;
    assign request_kind  = head.req;
    assign coord_x       = head.x;
    assign coord_y       = head.y;
    assign coord_z       = head.z;
    assign segment_total = head.total;
    assign end_of_run    = (head.kind == KIND_SUMMARY);

`ifndef SYNTHESIS
    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= Q_CW'(QDEPTH))
        else $error("result queue overfilled");

    // Segment count stays within the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg <= SEG_W'(MAX_SEGMENTS))
        else $error("segment count beyond limit");

    // Coordinate slot never reaches the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        ci_reg != 2'd3)
        else $error("coordinate slot out of range");

    // Last byte returns the parser to its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_byte) |=> (phase_reg == PH_FIRST && seg_reg == '0 && !innum_reg))
        else $error("parser not cleared after last byte");
`endif

endmodule
